// ===== rtl/direction_to_equirect_uv_top_macros.svh =====
// ---------------------------------------------------------------------------
// direction_to_equirect_uv_top_macros.svh
// Assertion macros for the equirectangular UV mapper. They compile to nothing
// when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef DIRECTION_TO_EQUIRECT_UV_TOP_MACROS_SVH
`define DIRECTION_TO_EQUIRECT_UV_TOP_MACROS_SVH
`ifndef SYNTH
// Checked on clk, skipped while rst_n is low
`define DUV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked on clk, also during reset
`define DUV_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DUV_ASSERT(label, prop)
`define DUV_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== rtl/d2euv_pkg.sv =====
// ---------------------------------------------------------------------------
// d2euv_pkg
// Shared widths, register indexes, angle table and coordinate rounding.
// ---------------------------------------------------------------------------
`default_nettype none
package d2euv_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;
  localparam int ANGLE_TBL_LEN     = 24;

  localparam int IN_W     = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 34;
  localparam int Y_W      = 16;
  localparam int ROOT_W   = 16;
  localparam int SQ_W     = 32;
  localparam int ANG_W    = 34;
  localparam int PHI_W    = 36;
  localparam int THETA_W  = 28;
  localparam int FULL_W   = 36;
  localparam int OUT_W    = 16;
  localparam int SIN_W    = 15;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

  localparam logic [CFG_W-1:0] ROW0_RST = 48'd16384;
  localparam logic [CFG_W-1:0] ROW1_RST = 48'd1073741824;
  localparam logic [CFG_W-1:0] ROW2_RST = 48'd70368744177664;

  // Advance strobe and valid for one pipeline segment
  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctrl_t;

  // Direction in the local frame
  typedef struct packed {
    logic signed [SUM_W-1:0] lx;
    logic signed [SUM_W-1:0] lz;
    logic signed [Y_W-1:0]   yc;
  } local_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] atan_turn(input int idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clamp a turn fraction to [0, 2^32-1], round half up to cb bits, saturate
  function automatic logic [OUT_W-1:0] to_coord(input logic signed [FULL_W-1:0] full,
                                                input int cb);
    logic [31:0] c;
    logic [32:0] q;
    logic [32:0] maxc;
    if (full < 0) begin
      c = '0;
    end else if (full > 36'sh0FFFFFFFF) begin
      c = '1;
    end else begin
      c = full[31:0];
    end
    q    = ({1'b0, c} + (33'd1 << (31 - cb))) >> (32 - cb);
    maxc = (33'd1 << cb) - 33'd1;
    if (q > maxc) begin
      q = maxc;
    end
    return q[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/d2euv_rot.sv =====
// ---------------------------------------------------------------------------
// d2euv_rot
// Three-stage matrix rotation: products, row sums, local y round and clamp.
// ---------------------------------------------------------------------------
`default_nettype none
module d2euv_rot (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire d2euv_pkg::pipe_ctrl_t             ctrl,
  input  wire logic signed [d2euv_pkg::IN_W-1:0] dir_x,
  input  wire logic signed [d2euv_pkg::IN_W-1:0] dir_y,
  input  wire logic signed [d2euv_pkg::IN_W-1:0] dir_z,
  input  wire logic [d2euv_pkg::CFG_W-1:0]       row0,
  input  wire logic [d2euv_pkg::CFG_W-1:0]       row1,
  input  wire logic [d2euv_pkg::CFG_W-1:0]       row2,
  output logic                                   vld_o,
  output d2euv_pkg::local_t                      loc_o
);

  localparam int PW = d2euv_pkg::PROD_W;
  localparam int SW = d2euv_pkg::SUM_W;

  logic signed [PW-1:0] prod_r [0:2][0:2];
  logic signed [PW-1:0] prod_nxt [0:2][0:2];
  logic signed [SW-1:0] lx_r, ly_r, lz_r;
  logic signed [SW-1:0] ly_rnd;
  logic signed [d2euv_pkg::Y_W-1:0] yc_nxt;
  d2euv_pkg::local_t    loc_r;
  logic                 v1_r, v2_r, v3_r;

  always_comb begin
    prod_nxt[0][0] = $signed(row0[15:0])  * dir_x;
    prod_nxt[0][1] = $signed(row0[31:16]) * dir_y;
    prod_nxt[0][2] = $signed(row0[47:32]) * dir_z;
    prod_nxt[1][0] = $signed(row1[15:0])  * dir_x;
    prod_nxt[1][1] = $signed(row1[31:16]) * dir_y;
    prod_nxt[1][2] = $signed(row1[47:32]) * dir_z;
    prod_nxt[2][0] = $signed(row2[15:0])  * dir_x;
    prod_nxt[2][1] = $signed(row2[31:16]) * dir_y;
    prod_nxt[2][2] = $signed(row2[47:32]) * dir_z;
  end

  // floor((y + 2^13) / 2^14), then clamp to one
  always_comb begin
    ly_rnd = (ly_r + 34'sd8192) >>> 14;
    if (ly_rnd > 34'sd16384) begin
      yc_nxt = 16'sd16384;
    end else if (ly_rnd < -34'sd16384) begin
      yc_nxt = -16'sd16384;
    end else begin
      yc_nxt = ly_rnd[d2euv_pkg::Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctrl.adv) begin
      v1_r <= ctrl.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      prod_r   <= prod_nxt;
      lx_r     <= SW'(prod_r[0][0]) + SW'(prod_r[0][1]) + SW'(prod_r[0][2]);
      ly_r     <= SW'(prod_r[1][0]) + SW'(prod_r[1][1]) + SW'(prod_r[1][2]);
      lz_r     <= SW'(prod_r[2][0]) + SW'(prod_r[2][1]) + SW'(prod_r[2][2]);
      loc_r.lx <= lx_r;
      loc_r.lz <= lz_r;
      loc_r.yc <= yc_nxt;
    end
  end

  assign vld_o = v3_r;
  assign loc_o = loc_r;

endmodule
`default_nettype wire

// ===== rtl/d2euv_sqrt.sv =====
// ---------------------------------------------------------------------------
// d2euv_sqrt
// Square of local y, then a one-bit-per-stage square root of 4*(1 - y^2).
// ---------------------------------------------------------------------------
`default_nettype none
module d2euv_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire d2euv_pkg::pipe_ctrl_t         ctrl,
  input  wire d2euv_pkg::local_t             loc_i,
  output logic                               vld_o,
  output d2euv_pkg::local_t                  loc_o,
  output logic [d2euv_pkg::ROOT_W-1:0]       root_o
);

  localparam int NB = d2euv_pkg::ROOT_W;
  localparam int QW = d2euv_pkg::SQ_W;

  logic [QW-1:0]         n_r   [0:NB];
  logic [QW-1:0]         res_r [0:NB];
  d2euv_pkg::local_t     side_r [0:NB];
  logic                  vld_r [0:NB];
  logic signed [QW-1:0]  sq;
  logic [QW-1:0]         w;

  always_comb begin
    sq = loc_i.yc * loc_i.yc;
    w  = 32'd268435456 - $unsigned(sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ctrl.adv) begin
      vld_r[0] <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      n_r[0]    <= w << 2;
      res_r[0]  <= '0;
      side_r[0] <= loc_i;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam logic [QW-1:0] BIT = QW'(1) << (2 * (NB - 1 - k));
    logic [QW-1:0] trial;
    logic [QW-1:0] n_nxt, res_nxt;

    always_comb begin
      trial = res_r[k] + BIT;
      if (n_r[k] >= trial) begin
        n_nxt   = n_r[k] - trial;
        res_nxt = (res_r[k] >> 1) + BIT;
      end else begin
        n_nxt   = n_r[k];
        res_nxt = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (ctrl.adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.adv) begin
        n_r[k+1]    <= n_nxt;
        res_r[k+1]  <= res_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign vld_o  = vld_r[NB];
  assign loc_o  = side_r[NB];
  assign root_o = res_r[NB][NB-1:0];

endmodule
`default_nettype wire

// ===== rtl/d2euv_cordic.sv =====
// ---------------------------------------------------------------------------
// d2euv_cordic
// Vectoring CORDIC, one micro-rotation per stage, angle in 2^-32 turn.
// ---------------------------------------------------------------------------
`default_nettype none
module d2euv_cordic #(
  parameter int W      = d2euv_pkg::PHI_W,
  parameter int STAGES = d2euv_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire d2euv_pkg::pipe_ctrl_t               ctrl,
  input  wire logic signed [W-1:0]                 x_i,
  input  wire logic signed [W-1:0]                 y_i,
  input  wire logic [SIDE_W-1:0]                   side_i,
  output logic                                     vld_o,
  output logic signed [d2euv_pkg::ANG_W-1:0]       ang_o,
  output logic [SIDE_W-1:0]                        side_o
);

  localparam int AW = d2euv_pkg::ANG_W;

  logic signed [W-1:0]  x_r [0:STAGES];
  logic signed [W-1:0]  y_r [0:STAGES];
  logic signed [AW-1:0] z_r [0:STAGES];
  logic                 zero_r [0:STAGES];
  logic [SIDE_W-1:0]    side_r [0:STAGES];
  logic                 vld_r [0:STAGES];

  // Fold the left half-plane over, start the angle at plus or minus a half turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ctrl.adv) begin
      vld_r[0] <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      side_r[0] <= side_i;
      if (x_i < 0) begin
        x_r[0] <= -x_i;
        y_r[0] <= -y_i;
        z_r[0] <= (y_i >= 0) ? 34'sd2147483648 : -34'sd2147483648;
      end else begin
        x_r[0] <= x_i;
        y_r[0] <= y_i;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = d2euv_pkg::atan_turn(i);
    logic signed [W-1:0] dx, dy;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (ctrl.adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.adv) begin
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN;
        end
      end
    end
  end

  assign vld_o  = vld_r[STAGES];
  assign ang_o  = zero_r[STAGES] ? '0 : z_r[STAGES];
  assign side_o = side_r[STAGES];

endmodule
`default_nettype wire

// ===== rtl/direction_to_equirect_uv_top.sv =====
// ---------------------------------------------------------------------------
// direction_to_equirect_uv_top
// Rotates a unit direction into the light frame and maps it to
// equirectangular u, v and the sine of the polar angle.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : valid/ready channel, one direction word (x, y, z in Q1.14).
//   out_*  : valid/ready channel, one word per input (tex_u, tex_v in
//            Q0.16, sin_theta in Q1.14), in input order.
//   cfg_*  : write port for the three matrix rows; write only while idle.
// Throughput: one word per cycle, sustained, as long as out_ready is high.
// Pipeline from input accept to out_valid: 3 rotation stages,
//   17 square-root stages, 1 + CORDIC_STAGES angle stages and
//   1 output register, with CORDIC_STAGES at its default of 16.
// Reset: synchronous, active low; empties the pipeline and loads the
//   identity matrix.
// Stall: the whole pipeline advances on one strobe. When the receiver
//   stalls, the word leaving the pipe drops into a skid register and the
//   strobe stops the next cycle; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none
`include "direction_to_equirect_uv_top_macros.svh"
module direction_to_equirect_uv_top #(
  parameter int CORDIC_STAGES = d2euv_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = d2euv_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [d2euv_pkg::IN_W-1:0]     in_dir_x,
  input  wire logic signed [d2euv_pkg::IN_W-1:0]     in_dir_y,
  input  wire logic signed [d2euv_pkg::IN_W-1:0]     in_dir_z,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [d2euv_pkg::OUT_W-1:0]                out_tex_u,
  output logic [d2euv_pkg::OUT_W-1:0]                out_tex_v,
  output logic [d2euv_pkg::SIN_W-1:0]                out_sin_theta,
  input  wire logic                                  cfg_we,
  input  wire logic [d2euv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [d2euv_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int SW   = d2euv_pkg::SUM_W;
  localparam int PW   = d2euv_pkg::PHI_W;
  localparam int TW   = d2euv_pkg::THETA_W;
  localparam int FW   = d2euv_pkg::FULL_W;
  localparam int OW   = d2euv_pkg::OUT_W;
  localparam int SNW  = d2euv_pkg::SIN_W;
  localparam int HI_W = 7;
  localparam int LO_W = SNW - HI_W;
  localparam int RES_W = 2 * OW + SNW;

  // Matrix rows
  logic [d2euv_pkg::CFG_W-1:0] row0_r, row1_r, row2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= d2euv_pkg::ROW0_RST;
      row1_r <= d2euv_pkg::ROW1_RST;
      row2_r <= d2euv_pkg::ROW2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        d2euv_pkg::REG_ROW0: row0_r <= cfg_wdata;
        d2euv_pkg::REG_ROW1: row1_r <= cfg_wdata;
        d2euv_pkg::REG_ROW2: row2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while the skid register is occupied
  logic                  skid_vld_r;
  logic [RES_W-1:0]      skid_dat_r;
  logic                  ov_r;
  logic [RES_W-1:0]      od_r;
  logic                  adv;
  d2euv_pkg::pipe_ctrl_t in_ctrl;

  assign adv      = !skid_vld_r;
  assign in_ready = adv;
  assign in_ctrl  = '{adv: adv, vld: in_valid};

  // Rotation
  logic              rot_vld;
  d2euv_pkg::local_t rot_loc;

  d2euv_rot u_rot (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (in_ctrl),
    .dir_x (in_dir_x),
    .dir_y (in_dir_y),
    .dir_z (in_dir_z),
    .row0  (row0_r),
    .row1  (row1_r),
    .row2  (row2_r),
    .vld_o (rot_vld),
    .loc_o (rot_loc)
  );

  // Sine of the polar angle, Q1.15 root
  logic                           sq_vld;
  d2euv_pkg::local_t              sq_loc;
  logic [d2euv_pkg::ROOT_W-1:0]   root;

  d2euv_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   ('{adv: adv, vld: rot_vld}),
    .loc_i  (rot_loc),
    .vld_o  (sq_vld),
    .loc_o  (sq_loc),
    .root_o (root)
  );

  // Round the root to Q1.14; ride it along the two angle pipes
  logic [d2euv_pkg::ROOT_W:0] sin_full;
  logic [SNW-1:0]             sin_q;
  assign sin_full = {1'b0, root} + 17'd1;
  assign sin_q    = sin_full[SNW:1];

  logic signed [PW-1:0] phi_x, phi_y;
  logic signed [TW-1:0] th_x, th_y;
  assign phi_x = PW'(sq_loc.lx);
  assign phi_y = PW'(sq_loc.lz);
  assign th_x  = -(TW'(sq_loc.yc) <<< 9);
  assign th_y  = TW'({1'b0, root}) <<< 8;

  logic                                phi_vld, th_vld;
  logic signed [d2euv_pkg::ANG_W-1:0]  phi_ang, th_ang;
  logic [HI_W-1:0]                     sin_hi;
  logic [LO_W-1:0]                     sin_lo;

  d2euv_cordic #(
    .W      (PW),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (HI_W)
  ) u_cordic_phi (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   ('{adv: adv, vld: sq_vld}),
    .x_i    (phi_x),
    .y_i    (phi_y),
    .side_i (sin_q[SNW-1:LO_W]),
    .vld_o  (phi_vld),
    .ang_o  (phi_ang),
    .side_o (sin_hi)
  );

  d2euv_cordic #(
    .W      (TW),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (LO_W)
  ) u_cordic_theta (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   ('{adv: adv, vld: sq_vld}),
    .x_i    (th_x),
    .y_i    (th_y),
    .side_i (sin_q[LO_W-1:0]),
    .vld_o  (th_vld),
    .ang_o  (th_ang),
    .side_o (sin_lo)
  );

  // u = phi + half turn, v = 2 * theta, both as turn fractions
  logic signed [FW-1:0] u_full, v_full;
  logic [RES_W-1:0]     pipe_dat;
  logic                 pipe_emit;

  assign u_full    = FW'(phi_ang) + 36'sd2147483648;
  assign v_full    = FW'(th_ang) <<< 1;
  assign pipe_dat  = {d2euv_pkg::to_coord(u_full, COORD_BITS),
                      d2euv_pkg::to_coord(v_full, COORD_BITS),
                      sin_hi, sin_lo};
  assign pipe_emit = adv && phi_vld;

  // Output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r       <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!ov_r || out_ready) begin
      if (skid_vld_r) begin
        ov_r       <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        ov_r <= pipe_emit;
      end
    end else if (pipe_emit) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || out_ready) begin
      od_r <= skid_vld_r ? skid_dat_r : pipe_dat;
    end else if (pipe_emit) begin
      skid_dat_r <= pipe_dat;
    end
  end

  assign out_valid     = ov_r;
  assign out_tex_u     = od_r[RES_W-1 -: OW];
  assign out_tex_v     = od_r[SNW +: OW];
  assign out_sin_theta = od_r[SNW-1:0];

  // Both angle pipes carry the same words in lockstep
  `DUV_ASSERT(a_angle_pipes_aligned, phi_vld == th_vld)
  // The skid register only fills behind a stalled output word
  `DUV_ASSERT(a_skid_behind_out, skid_vld_r |-> ov_r)
  `DUV_ASSERT(a_skid_fill_on_stall, $rose(skid_vld_r) |-> $past(ov_r && !out_ready))
  // Sine never exceeds one
  `DUV_ASSERT_ALWAYS(a_sin_range, out_valid |-> (out_sin_theta <= 15'd16384))

endmodule
`default_nettype wire
